>>> hw/rtl/lbc_pkg.sv
package lbc_pkg;

	localparam int MODE_W = 5;

	localparam logic [MODE_W-1:0] MODE_NORMAL       = 5'd0;
	localparam logic [MODE_W-1:0] MODE_DARKEN       = 5'd1;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY     = 5'd2;
	localparam logic [MODE_W-1:0] MODE_COLOR_BURN   = 5'd3;
	localparam logic [MODE_W-1:0] MODE_LINEAR_BURN  = 5'd4;
	localparam logic [MODE_W-1:0] MODE_LIGHTEN      = 5'd5;
	localparam logic [MODE_W-1:0] MODE_SCREEN       = 5'd6;
	localparam logic [MODE_W-1:0] MODE_COLOR_DODGE  = 5'd7;
	localparam logic [MODE_W-1:0] MODE_LINEAR_DODGE = 5'd8;
	localparam logic [MODE_W-1:0] MODE_OVERLAY      = 5'd9;
	localparam logic [MODE_W-1:0] MODE_SOFT_LIGHT   = 5'd10;
	localparam logic [MODE_W-1:0] MODE_HARD_LIGHT   = 5'd11;
	localparam logic [MODE_W-1:0] MODE_VIVID_LIGHT  = 5'd12;
	localparam logic [MODE_W-1:0] MODE_LINEAR_LIGHT = 5'd13;
	localparam logic [MODE_W-1:0] MODE_PIN_LIGHT    = 5'd14;
	localparam logic [MODE_W-1:0] MODE_DIFFERENCE   = 5'd15;
	localparam logic [MODE_W-1:0] MODE_EXCLUSION    = 5'd16;

	typedef struct packed {
		logic [7:0] layer_red;
		logic [7:0] layer_green;
		logic [7:0] layer_blue;
		logic [7:0] layer_alpha;
		logic [7:0] base_red;
		logic [7:0] base_green;
		logic [7:0] base_blue;
		logic [7:0] base_alpha;
	} in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} out_t;

endpackage

>>> hw/rtl/lbc_div.sv
module lbc_div
	import lbc_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS:0]   num,
	input  logic [FRAC_BITS:0]   den,
	input  logic [SIDE_W-1:0]    side_in,
	output logic [FRAC_BITS+1:0] quo,
	output logic [SIDE_W-1:0]    side_out
);

	localparam int F = FRAC_BITS;
	localparam int VW = F + 1;
	localparam int QW = F + 2;
	localparam int RW = 2 * F + 3;
	localparam int STEPS = F + 2;
	localparam logic [QW-1:0] QMAX = QW'(1) << (F + 1);

	logic [RW-1:0]     rem_q  [STEPS+1];
	logic [VW-1:0]     den_q  [STEPS+1];
	logic              ovf_q  [STEPS+1];
	logic [QW-1:0]     quo_q  [STEPS+1];
	logic [SIDE_W-1:0] side_q [STEPS+1];

	// quotient of num/den needs more than QW bits when num >= 4*den (den of zero too)
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= RW'(num) << F;
			den_q[0]  <= den;
			ovf_q[0]  <= (VW + 2)'(num) >= {den, 2'b00};
			quo_q[0]  <= '0;
			side_q[0] <= side_in;
		end
	end

	for (genvar j = 1; j <= STEPS; j++) begin : g_step
		localparam int K = STEPS - j;
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = RW'(den_q[j-1]) << K;
		assign ge  = rem_q[j-1] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= ge ? rem_q[j-1] - dsh : rem_q[j-1];
				den_q[j]  <= den_q[j-1];
				ovf_q[j]  <= ovf_q[j-1];
				quo_q[j]  <= quo_q[j-1] | (QW'(ge) << K);
				side_q[j] <= side_q[j-1];
			end
		end
	end

	assign quo = (ovf_q[STEPS] || quo_q[STEPS] > QMAX) ? QMAX : quo_q[STEPS];
	assign side_out = side_q[STEPS];

endmodule

>>> hw/rtl/lbc_lane.sv
module lbc_lane
	import lbc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              en,
	input  logic [MODE_W-1:0] mode,
	input  logic [7:0]        layer,
	input  logic [7:0]        base,
	input  logic [7:0]        alpha,
	output logic [7:0]        chan
);

	localparam int F = FRAC_BITS;
	localparam int VW = F + 1;
	localparam int QW = F + 2;
	localparam int SW = F + 3;
	localparam int SIDE_W = 3 * VW + 2;
	localparam logic [VW-1:0] ONE = VW'(1) << F;
	localparam logic [VW-1:0] HALF = VW'(1) << (F - 1);

	logic [VW-1:0] fx_tab [256];
	for (genvar i = 0; i < 256; i++) begin : g_tab
		assign fx_tab[i] = VW'((longint'(i) * (longint'(1) << F) + 254) / 255);
	end

	// stage 1: to fixed point
	logic [VW-1:0] s_s1, d_s1, a_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s1 <= fx_tab[layer];
			d_s1 <= fx_tab[base];
			a_s1 <= fx_tab[alpha];
		end
	end

	// stage 2: shared multiplier for the product modes
	logic [VW-1:0]   ma, mb;
	logic [2*VW-1:0] prod;
	logic            shi1, dhi1;
	assign shi1 = s_s1 > HALF;
	assign dhi1 = d_s1 > HALF;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (mode)
			MODE_MULTIPLY, MODE_EXCLUSION: begin
				ma = s_s1;
				mb = d_s1;
			end
			MODE_SCREEN: begin
				ma = ONE - d_s1;
				mb = ONE - s_s1;
			end
			MODE_OVERLAY: begin
				ma = dhi1 ? {d_s1[VW-2:0], 1'b0} - ONE : {d_s1[VW-2:0], 1'b0};
				mb = dhi1 ? ONE - s_s1 : s_s1;
			end
			MODE_SOFT_LIGHT: begin
				ma = shi1 ? ONE - d_s1 : d_s1;
				mb = shi1 ? ONE + HALF - s_s1 : s_s1 + HALF;
			end
			MODE_HARD_LIGHT: begin
				ma = shi1 ? {s_s1[VW-2:0], 1'b0} - ONE : {s_s1[VW-2:0], 1'b0};
				mb = shi1 ? ONE - d_s1 : d_s1;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;

	logic [VW-1:0] s_s2, d_s2, a_s2, p_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= s_s1;
			d_s2 <= d_s1;
			a_s2 <= a_s1;
			p_s2 <= prod[F+VW-1:F];
		end
	end

	// blend value for the modes without a quotient, and divider operands
	logic signed [SW-1:0] sx, dx, px, onex, tx, bx;
	logic [VW-1:0]        pre, num, den, s2x;
	logic                 shi2, dhi2, is_div, is_burn;

	assign sx   = signed'({2'b00, s_s2});
	assign dx   = signed'({2'b00, d_s2});
	assign px   = signed'({2'b00, p_s2});
	assign onex = signed'({2'b00, ONE});
	assign shi2 = s_s2 > HALF;
	assign dhi2 = d_s2 > HALF;
	assign s2x  = {s_s2[VW-2:0], 1'b0};

	always_comb begin
		tx = shi2 ? sx + sx - onex : sx + sx;
		unique case (mode)
			MODE_DARKEN:       bx = (dx < sx) ? dx : sx;
			MODE_MULTIPLY:     bx = px;
			MODE_LINEAR_BURN:  bx = dx + sx - onex;
			MODE_LIGHTEN:      bx = (dx > sx) ? dx : sx;
			MODE_SCREEN:       bx = onex - px;
			MODE_LINEAR_DODGE: bx = dx + sx;
			MODE_OVERLAY:      bx = dhi2 ? onex - px : px;
			MODE_SOFT_LIGHT:   bx = shi2 ? onex - px : px;
			MODE_HARD_LIGHT:   bx = shi2 ? onex - px : px;
			MODE_LINEAR_LIGHT: bx = dx + sx + sx - onex;
			MODE_PIN_LIGHT: begin
				if (shi2)
					bx = (dx > tx) ? dx : tx;
				else
					bx = (dx < tx) ? dx : tx;
			end
			MODE_DIFFERENCE:   bx = (dx > sx) ? dx - sx : sx - dx;
			MODE_EXCLUSION:    bx = sx + dx - px - px;
			default:           bx = sx;
		endcase
	end

	assign pre = (bx < 0) ? '0 : ((bx > onex) ? ONE : bx[VW-1:0]);

	always_comb begin
		is_div  = 1'b0;
		is_burn = 1'b0;
		num     = '0;
		den     = '0;
		unique case (mode)
			MODE_COLOR_BURN: begin
				is_div  = 1'b1;
				is_burn = 1'b1;
				num     = ONE - d_s2;
				den     = s_s2;
			end
			MODE_COLOR_DODGE: begin
				is_div = 1'b1;
				num    = d_s2;
				den    = ONE - s_s2;
			end
			MODE_VIVID_LIGHT: begin
				is_div  = 1'b1;
				is_burn = !shi2;
				num     = shi2 ? d_s2 : ONE - d_s2;
				den     = shi2 ? ONE - (s2x - ONE) : s2x;
			end
			default: begin
				is_div = 1'b0;
			end
		endcase
	end

	logic [QW-1:0]     r;
	logic [SIDE_W-1:0] side_o;

	lbc_div #(
		.FRAC_BITS(FRAC_BITS),
		.SIDE_W   (SIDE_W)
	) u_div (
		.clk     (clk),
		.en      (en),
		.num     (num),
		.den     (den),
		.side_in ({pre, is_div, is_burn, d_s2, a_s2}),
		.quo     (r),
		.side_out(side_o)
	);

	logic [VW-1:0]   pre_d, d_d, a_d, b;
	logic            div_d, burn_d;
	logic [2*VW-1:0] prod1, prod2;

	assign {pre_d, div_d, burn_d, d_d, a_d} = side_o;

	always_comb begin
		if (!div_d)
			b = pre_d;
		else if (burn_d)
			b = (r >= QW'(ONE)) ? '0 : ONE - r[VW-1:0];
		else
			b = (r > QW'(ONE)) ? ONE : r[VW-1:0];
	end

	assign prod1 = b * a_d;

	// composite: b*A, then d*(1-A) and the sum
	logic [VW-1:0] p1_s4, d_s4, a_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s4 <= prod1[F+VW-1:F];
			d_s4  <= d_d;
			a_s4  <= a_d;
		end
	end

	assign prod2 = d_s4 * (ONE - a_s4);

	logic [VW:0] sum_s5;
	always_ff @(posedge clk) begin
		if (en)
			sum_s5 <= {1'b0, p1_s4} + {1'b0, prod2[F+VW-1:F]};
	end

	logic [VW-1:0]   m;
	logic [VW+7:0]   scaled;
	assign m      = (sum_s5 > {1'b0, ONE}) ? ONE : sum_s5[VW-1:0];
	assign scaled = m * (VW + 8)'(255);
	assign chan   = scaled[F+7:F];

endmodule

>>> hw/rtl/layer_blend_composite.sv
// Layer blend and alpha composite, one pixel pair per item.
// in_data carries a layer and a base RGBA pixel; out_data returns the merged
// pixel. Both channels use valid/ready. cfg_we/cfg_wdata write the blend
// mode; write it only while no item is in flight.
// Red, green and blue each run in their own lane: fixed-point conversion,
// one product stage, a restoring divider of FRAC_BITS+2 one-bit stages for
// the burn and dodge modes, then a two-stage composite. The alpha sum and
// the three lanes meet in the output register.
// Throughput: one item per cycle unless stalled; lanes are fully pipelined.
// When out_ready is low while a result waits, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// Reset clears the valid bits and the mode (normal); the datapath registers
// are not reset.
module layer_blend_composite
	import lbc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata
);

	localparam int LAT = FRAC_BITS + 7;

	logic [MODE_W-1:0] mode_q;
	logic [LAT-1:0]    vld_q;
	logic [7:0]        asum_q [LAT];
	logic              out_valid_q;
	out_t              out_q;
	logic              en;
	logic [8:0]        asum;
	logic [7:0]        red, green, blue;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;
	assign asum = {1'b0, in_data.layer_alpha} + {1'b0, in_data.base_alpha};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LAT-2:0], in_valid};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			asum_q[0] <= asum[8] ? 8'd255 : asum[7:0];
			for (int i = 1; i < LAT; i++)
				asum_q[i] <= asum_q[i-1];
			out_q <= '{out_red: red, out_green: green, out_blue: blue,
				out_alpha: asum_q[LAT-1]};
		end
	end

	lbc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
		.clk(clk), .en(en), .mode(mode_q),
		.layer(in_data.layer_red), .base(in_data.base_red),
		.alpha(in_data.layer_alpha), .chan(red)
	);

	lbc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_g (
		.clk(clk), .en(en), .mode(mode_q),
		.layer(in_data.layer_green), .base(in_data.base_green),
		.alpha(in_data.layer_alpha), .chan(green)
	);

	lbc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
		.clk(clk), .en(en), .mode(mode_q),
		.layer(in_data.layer_blue), .base(in_data.base_blue),
		.alpha(in_data.layer_alpha), .chan(blue)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
